### design/npime_pkg.sv
// ----------------------------------------------------------------------------
// npime_pkg: shared definitions for the NPI minimum-entropy distribution block
// Holds the default sizes, the fixed result field widths and the control
// store (microcode) of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package npime_pkg;

   // Default sizes of the block.
   localparam int MAX_CATEGORIES_DEF = 32;
   localparam int COUNT_BITS_DEF     = 16;

   // Fixed widths of the result fields.
   localparam int CAT_W      = 5;
   localparam int NUM_W      = 17;
   localparam int TOTAL_W    = 21;
   localparam int RSP_DATA_W = ((CAT_W + NUM_W + TOTAL_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - (CAT_W + NUM_W + TOTAL_W);

   // Microcode program counter width.
   localparam int UPC_W = 4;

   // Datapath operation selected by a control word.
   typedef enum logic [3:0] {
      OP_LOAD,
      OP_SETUP_START,
      OP_SETUP,
      OP_MASS,
      OP_PASS_START,
      OP_SCAN,
      OP_PICK,
      OP_UPDATE,
      OP_OUT_START,
      OP_OUT,
      OP_CLEAR
   } op_type;

   // Jump condition selected by a control word.
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_LOAD_END,
      COND_IDX_END,
      COND_MASS_ZERO,
      COND_NOT_FOUND,
      COND_OUT_END
   } cond_type;

   // One control word: operation, jump condition, target, and whether the
   // sequencer holds its step when the condition is false.
   typedef struct packed {
      op_type           op;
      cond_type         cond;
      logic             stay;
      logic [UPC_W-1:0] target;
   } uword_type;

   // Program step addresses.
   localparam logic [UPC_W-1:0] UPC_LOAD        = 4'd0;
   localparam logic [UPC_W-1:0] UPC_SETUP_START = 4'd1;
   localparam logic [UPC_W-1:0] UPC_SETUP       = 4'd2;
   localparam logic [UPC_W-1:0] UPC_MASS        = 4'd3;
   localparam logic [UPC_W-1:0] UPC_PASS_START  = 4'd4;
   localparam logic [UPC_W-1:0] UPC_SCAN        = 4'd5;
   localparam logic [UPC_W-1:0] UPC_PICK        = 4'd6;
   localparam logic [UPC_W-1:0] UPC_UPDATE      = 4'd7;
   localparam logic [UPC_W-1:0] UPC_OUT_START   = 4'd8;
   localparam logic [UPC_W-1:0] UPC_OUT         = 4'd9;
   localparam logic [UPC_W-1:0] UPC_CLEAR       = 4'd10;

   // Control store. Unused addresses fall back to the load step.
   function automatic uword_type npime_ucode(input logic [UPC_W-1:0] pc);
      uword_type w;
      unique case (pc)
         UPC_LOAD:        w = '{OP_LOAD,        COND_LOAD_END,  1'b1, UPC_SETUP_START};
         UPC_SETUP_START: w = '{OP_SETUP_START, COND_NEXT,      1'b0, UPC_SETUP};
         UPC_SETUP:       w = '{OP_SETUP,       COND_IDX_END,   1'b1, UPC_MASS};
         UPC_MASS:        w = '{OP_MASS,        COND_NEXT,      1'b0, UPC_PASS_START};
         UPC_PASS_START:  w = '{OP_PASS_START,  COND_MASS_ZERO, 1'b0, UPC_OUT_START};
         UPC_SCAN:        w = '{OP_SCAN,        COND_IDX_END,   1'b1, UPC_PICK};
         UPC_PICK:        w = '{OP_PICK,        COND_NOT_FOUND, 1'b0, UPC_OUT_START};
         UPC_UPDATE:      w = '{OP_UPDATE,      COND_ALWAYS,    1'b0, UPC_PASS_START};
         UPC_OUT_START:   w = '{OP_OUT_START,   COND_NEXT,      1'b0, UPC_OUT};
         UPC_OUT:         w = '{OP_OUT,         COND_OUT_END,   1'b1, UPC_CLEAR};
         UPC_CLEAR:       w = '{OP_CLEAR,       COND_ALWAYS,    1'b0, UPC_LOAD};
         default:         w = '{OP_LOAD,        COND_ALWAYS,    1'b0, UPC_LOAD};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### design/npime_ram.sv
// ----------------------------------------------------------------------------
// npime_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module npime_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### design/npi_min_entropy_distribution_top.sv
// ----------------------------------------------------------------------------
// npi_min_entropy_distribution_top: NPI minimum-entropy distribution
// Loads per-category counts, then hands out the probability mass greedily
// and streams one numerator per category together with the common total.
// ----------------------------------------------------------------------------
// Counts enter one request per cycle, in category order, the run closed by
// tlast (or by filling the last category slot). After the closing request
// the block stops taking requests and evaluates. It first sets up the lower
// bounds and the mass left over. Then come up to n greedy passes (every pass
// scans the lower-bound RAM one entry per cycle through its single read
// port), and a final check that the mass is used up. Results stream out
// one per category, with tlast on the last one, and wait while the receiver
// stalls. A result is numerator and total; probability is numerator
// divided by total. The next run may start loading while the final result
// still waits in the output register.
`default_nettype none

module npi_min_entropy_distribution_top
   import npime_pkg::*;
#(
   parameter int MAX_CATEGORIES = MAX_CATEGORIES_DEF,
   parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Request channel.
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [((COUNT_BITS + 7) / 8) * 8-1:0]  req_tdata,  // [COUNT_BITS-1:0] count
   input  wire logic                                   req_tlast,  // last category
   // Result channel.
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic      [RSP_DATA_W-1:0]                  rsp_tdata,  // category, numerator, total
   output logic                                        rsp_tlast   // result of last category
);

   localparam int IDX_W   = $clog2(MAX_CATEGORIES);
   localparam int TALLY_W = $clog2(MAX_CATEGORIES + 1);
   localparam int LOW_W   = COUNT_BITS + 1;
   localparam int TOT_W   = COUNT_BITS + $clog2(MAX_CATEGORIES);

   // Sequencer and control state.
   logic [UPC_W-1:0]          pc_ff, pc_in;
   uword_type                 ctrl;
   logic                      cond_hit;
   logic [TALLY_W-1:0]        tally_ff, tally_in;
   logic [TOT_W-1:0]          total_ff, total_in;
   logic [TOT_W-1:0]          rem_ff, rem_in;
   logic [MAX_CATEGORIES-1:0] elig_ff, elig_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic                      found_ff, found_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [TOT_W-1:0]          sum_ff, sum_in;
   logic [IDX_W-1:0]          best_idx_ff, best_idx_in;
   logic [LOW_W-1:0]          best_val_ff, best_val_in;
   logic [CAT_W-1:0]          rsp_cat_ff, rsp_cat_in;
   logic [NUM_W-1:0]          rsp_num_ff, rsp_num_in;
   logic [TOTAL_W-1:0]        rsp_total_ff, rsp_total_in;
   logic                      rsp_last_ff, rsp_last_in;

   // RAM ports.
   logic                      cnt_we;
   logic [IDX_W-1:0]          cnt_waddr, cnt_raddr;
   logic [COUNT_BITS-1:0]     cnt_wdata, cnt_rdata;
   logic                      low_we;
   logic [IDX_W-1:0]          low_waddr, low_raddr;
   logic [LOW_W-1:0]          low_wdata, low_rdata;

   // Helper values.
   logic                      req_accept;
   logic                      rsp_accept;
   logic                      tally_full;
   logic [TALLY_W-1:0]        tally_m1;
   logic [IDX_W-1:0]          last_idx;
   logic                      idx_end;
   logic                      out_adv;
   logic [COUNT_BITS-1:0]     req_count;
   logic [LOW_W-1:0]          setup_lower;
   logic [LOW_W-1:0]          cnt_p1;
   logic [LOW_W-1:0]          upper;
   logic [LOW_W-1:0]          diff;

   npime_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (MAX_CATEGORIES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   npime_ram #(
      .WIDTH (LOW_W),
      .DEPTH (MAX_CATEGORIES)
   ) u_lower_ram (
      .clock   (clock),
      .wr_en   (low_we),
      .wr_addr (low_waddr),
      .wr_data (low_wdata),
      .rd_addr (low_raddr),
      .rd_data (low_rdata)
   );

   // Control word fetch and handshake terms.
   assign ctrl       = npime_ucode(pc_ff);
   assign req_tready = (ctrl.op == OP_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_valid_ff && rsp_tready;
   assign req_count  = req_tdata[COUNT_BITS-1:0];
   assign tally_full = (tally_ff == TALLY_W'(MAX_CATEGORIES - 1));
   assign tally_m1   = tally_ff - TALLY_W'(1);
   assign last_idx   = tally_m1[IDX_W-1:0];
   assign idx_end    = (idx_ff == last_idx);
   assign out_adv    = !rsp_valid_ff || rsp_tready;

   // Arithmetic of the setup and update steps.
   assign setup_lower = (cnt_rdata == '0) ? '0 : LOW_W'(cnt_rdata) - LOW_W'(1);
   assign cnt_p1      = LOW_W'(cnt_rdata) + LOW_W'(1);
   assign upper       = (TOT_W'(cnt_p1) > total_ff) ? total_ff[LOW_W-1:0] : cnt_p1;
   assign diff        = upper - best_val_ff;

   // Jump condition of the current control word.
   always_comb begin
      unique case (ctrl.cond)
         COND_NEXT:      cond_hit = 1'b0;
         COND_ALWAYS:    cond_hit = 1'b1;
         COND_LOAD_END:  cond_hit = req_accept && (req_tlast || tally_full);
         COND_IDX_END:   cond_hit = idx_end;
         COND_MASS_ZERO: cond_hit = (rem_ff == '0);
         COND_NOT_FOUND: cond_hit = !found_ff;
         COND_OUT_END:   cond_hit = out_adv && idx_end;
         default:        cond_hit = 1'b0;
      endcase
   end

   // Next step and datapath operation.
   always_comb begin
      if (cond_hit) begin
         pc_in = ctrl.target;
      end else if (ctrl.stay) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + UPC_W'(1);
      end

      tally_in     = tally_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      elig_in      = elig_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      sum_in       = sum_ff;
      best_idx_in  = best_idx_ff;
      best_val_in  = best_val_ff;
      rsp_cat_in   = rsp_cat_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_accept ? 1'b0 : rsp_valid_ff;

      cnt_we    = 1'b0;
      cnt_waddr = tally_ff[IDX_W-1:0];
      cnt_wdata = req_count;
      cnt_raddr = idx_ff;
      low_we    = 1'b0;
      low_waddr = idx_ff;
      low_wdata = setup_lower;
      low_raddr = idx_ff;

      unique case (ctrl.op)
         // Store the count and add it to the total.
         OP_LOAD: begin
            if (req_accept) begin
               cnt_we   = 1'b1;
               tally_in = tally_ff + TALLY_W'(1);
               total_in = total_ff + TOT_W'(req_count);
            end
         end
         OP_SETUP_START: begin
            idx_in    = '0;
            sum_in    = '0;
            cnt_raddr = '0;
         end
         // Lower bound per category, summed up.
         OP_SETUP: begin
            low_we    = 1'b1;
            sum_in    = sum_ff + TOT_W'(setup_lower);
            idx_in    = idx_ff + IDX_W'(1);
            cnt_raddr = idx_ff + IDX_W'(1);
         end
         OP_MASS: begin
            rem_in = (total_ff > sum_ff) ? total_ff - sum_ff : '0;
         end
         OP_PASS_START: begin
            idx_in    = '0;
            found_in  = 1'b0;
            low_raddr = '0;
         end
         // Largest lower value among eligible categories, first on ties.
         OP_SCAN: begin
            if (elig_ff[idx_ff] && (!found_ff || low_rdata > best_val_ff)) begin
               found_in    = 1'b1;
               best_idx_in = idx_ff;
               best_val_in = low_rdata;
            end
            idx_in    = idx_ff + IDX_W'(1);
            low_raddr = idx_ff + IDX_W'(1);
         end
         OP_PICK: begin
            cnt_raddr = best_idx_ff;
         end
         // Raise the chosen category to its upper bound or by the mass left.
         OP_UPDATE: begin
            low_we    = 1'b1;
            low_waddr = best_idx_ff;
            if (TOT_W'(diff) < rem_ff) begin
               low_wdata            = upper;
               elig_in[best_idx_ff] = 1'b0;
               rem_in               = rem_ff - TOT_W'(diff);
            end else begin
               low_wdata = best_val_ff + rem_ff[LOW_W-1:0];
               rem_in    = '0;
            end
         end
         OP_OUT_START: begin
            idx_in    = '0;
            low_raddr = '0;
         end
         // Move one result into the output register when it is free.
         OP_OUT: begin
            if (out_adv) begin
               rsp_valid_in = 1'b1;
               rsp_cat_in   = CAT_W'(idx_ff);
               rsp_num_in   = NUM_W'(low_rdata);
               rsp_total_in = TOTAL_W'(total_ff);
               rsp_last_in  = idx_end;
               idx_in       = idx_ff + IDX_W'(1);
               low_raddr    = idx_ff + IDX_W'(1);
            end
         end
         OP_CLEAR: begin
            tally_in = '0;
            total_in = '0;
            rem_in   = '0;
            elig_in  = '1;
         end
         default: begin
            pc_in = UPC_LOAD;
         end
      endcase
   end

   // State and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= UPC_LOAD;
         tally_ff     <= '0;
         total_ff     <= '0;
         rem_ff       <= '0;
         elig_ff      <= '1;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         tally_ff     <= tally_in;
         total_ff     <= total_in;
         rem_ff       <= rem_in;
         elig_ff      <= elig_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_ff       <= sum_in;
      best_idx_ff  <= best_idx_in;
      best_val_ff  <= best_val_in;
      rsp_cat_ff   <= rsp_cat_in;
      rsp_num_ff   <= rsp_num_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Result channel.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_total_ff, rsp_num_ff, rsp_cat_ff};

endmodule

`default_nettype wire
